>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the checkers of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle property");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle property");

`endif

>>> hw/rtl/eadg_pkg.sv
// ----------------------------------------------------------------------------
// eadg_pkg
// Types, register indexes and the throttle code function of the ESC arm and
// direction gate.
// ----------------------------------------------------------------------------
`default_nettype none

package eadg_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 26;
  localparam int CFG_TIME_W  = 26;
  localparam int CHANNELS    = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_STARTUP  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PREARM   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POST     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REFRESH  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BURST    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REVERSED = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN     = 3'd6;

  localparam logic [CFG_TIME_W-1:0] STARTUP_RESET = 26'd500000;
  localparam logic [CFG_TIME_W-1:0] PREARM_RESET  = 26'd1000000;
  localparam logic [CFG_TIME_W-1:0] POST_RESET    = 26'd100000;
  localparam logic [CFG_TIME_W-1:0] REFRESH_RESET = 26'd2000000;
  localparam logic [7:0]            BURST_RESET   = 8'd10;
  localparam logic [3:0]            REV_RESET     = 4'd0;
  localparam logic [3:0]            OPEN_RESET    = 4'd15;

  localparam logic [15:0] IDLE_LEVEL = 16'd16384;
  localparam logic [15:0] FULL_LEVEL = 16'd32768;
  localparam logic [24:0] CODE_SPAN  = 25'd1999;
  localparam logic [24:0] ROUND_HALF = 25'd8192;
  localparam logic [10:0] CODE_BASE  = 11'd48;

  typedef enum logic [2:0] {
    PH_DISARMED = 3'd0,
    PH_PREARM   = 3'd1,
    PH_SEND     = 3'd2,
    PH_POST     = 3'd3,
    PH_READY    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_STOP = 2'd0,
    KIND_DIR  = 2'd1,
    KIND_THR  = 2'd2
  } frame_kind_t;

  typedef struct packed {
    logic        arm_request;
    logic [31:0] now_time;
    logic        link_ok;
    logic [2:0]  value_count;
    logic [15:0] throttle_a;
    logic [15:0] throttle_b;
    logic [15:0] throttle_c;
    logic [15:0] throttle_d;
  } slot_t;

  typedef struct packed {
    frame_kind_t frame_kind;
    logic [3:0]  send_mask;
    logic [3:0]  direction_bits;
    logic [10:0] code_a;
    logic [10:0] code_b;
    logic [10:0] code_c;
    logic [10:0] code_d;
    phase_t      gate_phase;
  } frame_t;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    frame_kind_t                 kind;
    logic [3:0]                  send_mask;
    logic [3:0]                  direction_bits;
    phase_t                      phase;
    logic [2:0]                  value_count;
    logic [CHANNELS-1:0][15:0]   throttle;
  } cmd_t;

  function automatic logic [10:0] throttle_code(input logic [15:0] u);
    logic [15:0] c;
    logic [14:0] d;
    logic [24:0] p;
    c = (u > FULL_LEVEL) ? FULL_LEVEL : u;
    d = 15'(c - IDLE_LEVEL);
    p = 25'(d) * CODE_SPAN + ROUND_HALF;
    if (u <= IDLE_LEVEL) begin
      return 11'd0;
    end
    return CODE_BASE + p[24:14];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/eadg_queue.sv
// ----------------------------------------------------------------------------
// eadg_queue
// Short request queue between the classifying front part and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module eadg_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire eadg_pkg::cmd_t push_data,
  output logic               push_ready,
  input  wire logic          pop,
  output logic               pop_valid,
  output eadg_pkg::cmd_t     pop_data
);

  localparam int DEPTH = eadg_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  eadg_pkg::cmd_t   entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/eadg_front.sv
// ----------------------------------------------------------------------------
// eadg_front
// Configuration registers and the arm and direction state machine; classifies
// each slot into a stop, direction or throttle request.
// ----------------------------------------------------------------------------
`default_nettype none

module eadg_front #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [eadg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [eadg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               slot_valid,
  output logic                                    slot_ready,
  input  wire eadg_pkg::slot_t                    slot,
  output logic                                    push,
  input  wire logic                               push_ready,
  output eadg_pkg::cmd_t                          cmd
);

  logic [eadg_pkg::CFG_TIME_W-1:0] startup_stop_time;
  logic [eadg_pkg::CFG_TIME_W-1:0] prearm_stop_time;
  logic [eadg_pkg::CFG_TIME_W-1:0] post_command_stop_time;
  logic [eadg_pkg::CFG_TIME_W-1:0] refresh_period;
  logic [7:0]                      burst_length;
  logic [3:0]                      reversed_mask;
  logic [3:0]                      open_mask;

  eadg_pkg::phase_t     phase, phase_next;
  logic [TIME_BITS-1:0] deadline, deadline_next;
  logic [7:0]           frames_sent, frames_sent_next;
  logic                 burst_for_arm, burst_for_arm_next;
  logic                 last_arm;
  logic                 pending_burst, pending_burst_next;

  eadg_pkg::frame_kind_t kind;
  logic [TIME_BITS-1:0]  now_t;
  logic [TIME_BITS-1:0]  since;
  logic                  old_reached;

  // A deadline set in this slot from now_time is reached exactly when the
  // wrapped negation of its delay has the top bit clear.
  function automatic logic fresh_reached(input logic [TIME_BITS-1:0] d);
    logic [TIME_BITS-1:0] n;
    n = -d;
    return !n[TIME_BITS-1];
  endfunction

  assign slot_ready  = push_ready;
  assign push        = slot_valid && push_ready;
  assign now_t       = TIME_BITS'(slot.now_time);
  assign since       = now_t - deadline;
  assign old_reached = !since[TIME_BITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      startup_stop_time      <= eadg_pkg::STARTUP_RESET;
      prearm_stop_time       <= eadg_pkg::PREARM_RESET;
      post_command_stop_time <= eadg_pkg::POST_RESET;
      refresh_period         <= eadg_pkg::REFRESH_RESET;
      burst_length           <= eadg_pkg::BURST_RESET;
      reversed_mask          <= eadg_pkg::REV_RESET;
      open_mask              <= eadg_pkg::OPEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        eadg_pkg::REG_STARTUP:  startup_stop_time      <= cfg_data;
        eadg_pkg::REG_PREARM:   prearm_stop_time       <= cfg_data;
        eadg_pkg::REG_POST:     post_command_stop_time <= cfg_data;
        eadg_pkg::REG_REFRESH:  refresh_period         <= cfg_data;
        eadg_pkg::REG_BURST:    burst_length           <= cfg_data[7:0];
        eadg_pkg::REG_REVERSED: reversed_mask          <= cfg_data[3:0];
        eadg_pkg::REG_OPEN:     open_mask              <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= eadg_pkg::PH_DISARMED;
      deadline      <= TIME_BITS'(eadg_pkg::STARTUP_RESET);
      frames_sent   <= '0;
      burst_for_arm <= 1'b0;
      last_arm      <= 1'b0;
      pending_burst <= 1'b0;
    end else if (push) begin
      phase         <= phase_next;
      deadline      <= deadline_next;
      frames_sent   <= frames_sent_next;
      burst_for_arm <= burst_for_arm_next;
      last_arm      <= slot.arm_request;
      pending_burst <= pending_burst_next;
    end
  end

  always_comb begin
    logic                 set_dl;
    logic [TIME_BITS-1:0] delay;
    logic [7:0]           fs_inc;
    logic                 arm;
    phase_next         = phase;
    frames_sent_next   = frames_sent;
    burst_for_arm_next = burst_for_arm;
    set_dl             = 1'b0;
    delay              = TIME_BITS'(startup_stop_time);
    kind               = eadg_pkg::KIND_STOP;
    fs_inc             = frames_sent + 8'd1;
    arm                = slot.arm_request;

    // The previous direction frame counts only once the link confirms it.
    if (pending_burst && slot.link_ok) begin
      frames_sent_next = fs_inc;
      if (fs_inc >= burst_length) begin
        frames_sent_next = '0;
        set_dl           = 1'b1;
        if (burst_for_arm) begin
          phase_next = eadg_pkg::PH_POST;
          delay      = TIME_BITS'(post_command_stop_time);
        end else begin
          phase_next = eadg_pkg::PH_DISARMED;
          delay      = TIME_BITS'(refresh_period);
        end
      end
    end

    if (arm && !last_arm) begin
      phase_next         = eadg_pkg::PH_PREARM;
      set_dl             = 1'b1;
      delay              = TIME_BITS'(prearm_stop_time);
      frames_sent_next   = '0;
      burst_for_arm_next = 1'b1;
    end else if (!arm && last_arm) begin
      phase_next         = eadg_pkg::PH_DISARMED;
      set_dl             = 1'b1;
      delay              = TIME_BITS'(startup_stop_time);
      frames_sent_next   = '0;
      burst_for_arm_next = 1'b0;
    end

    if (arm) begin
      if (phase_next == eadg_pkg::PH_PREARM &&
          (set_dl ? fresh_reached(delay) : old_reached)) begin
        phase_next         = eadg_pkg::PH_SEND;
        frames_sent_next   = '0;
        burst_for_arm_next = 1'b1;
      end
      if (phase_next == eadg_pkg::PH_SEND && burst_for_arm_next) begin
        kind = eadg_pkg::KIND_DIR;
      end else if (phase_next == eadg_pkg::PH_POST) begin
        if (set_dl ? fresh_reached(delay) : old_reached) begin
          phase_next = eadg_pkg::PH_READY;
          kind       = eadg_pkg::KIND_THR;
        end
      end else if (phase_next == eadg_pkg::PH_READY) begin
        kind = eadg_pkg::KIND_THR;
      end
    end else begin
      if (phase_next != eadg_pkg::PH_DISARMED &&
          !(phase_next == eadg_pkg::PH_SEND && !burst_for_arm_next)) begin
        phase_next         = eadg_pkg::PH_DISARMED;
        set_dl             = 1'b1;
        delay              = TIME_BITS'(startup_stop_time);
        frames_sent_next   = '0;
        burst_for_arm_next = 1'b0;
      end
      if (phase_next == eadg_pkg::PH_DISARMED &&
          (set_dl ? fresh_reached(delay) : old_reached)) begin
        phase_next         = eadg_pkg::PH_SEND;
        frames_sent_next   = '0;
        burst_for_arm_next = 1'b0;
      end
      if (phase_next == eadg_pkg::PH_SEND && !burst_for_arm_next) begin
        kind = eadg_pkg::KIND_DIR;
      end
    end

    pending_burst_next = (kind == eadg_pkg::KIND_DIR);
    deadline_next      = set_dl ? now_t + delay : deadline;
  end

  always_comb begin
    cmd.kind           = kind;
    cmd.send_mask      = open_mask;
    cmd.direction_bits = (kind == eadg_pkg::KIND_DIR) ? (reversed_mask & open_mask) : 4'd0;
    cmd.phase          = phase_next;
    cmd.value_count    = slot.value_count;
    cmd.throttle[0]    = slot.throttle_a;
    cmd.throttle[1]    = slot.throttle_b;
    cmd.throttle[2]    = slot.throttle_c;
    cmd.throttle[3]    = slot.throttle_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/eadg_back.sv
// ----------------------------------------------------------------------------
// eadg_back
// Takes classified requests from the queue, forms the ESC codes and holds the
// finished frame in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eadg_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pop_valid,
  input  wire eadg_pkg::cmd_t pop_data,
  output logic                pop,
  output logic                frame_valid,
  input  wire logic           frame_ready,
  output eadg_pkg::frame_t    frame
);

  logic [eadg_pkg::CHANNELS-1:0][10:0] code;

  assign pop = pop_valid && (!frame_valid || frame_ready);

  always_comb begin
    for (int i = 0; i < eadg_pkg::CHANNELS; i++) begin
      if (pop_data.kind == eadg_pkg::KIND_THR && pop_data.send_mask[i] &&
          3'(i) < pop_data.value_count) begin
        code[i] = eadg_pkg::throttle_code(pop_data.throttle[i]);
      end else begin
        code[i] = 11'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame.frame_kind     <= pop_data.kind;
      frame.send_mask      <= pop_data.send_mask;
      frame.direction_bits <= pop_data.direction_bits;
      frame.code_a         <= code[0];
      frame.code_b         <= code[1];
      frame.code_c         <= code[2];
      frame.code_d         <= code[3];
      frame.gate_phase     <= pop_data.phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (pop) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/esc_arm_direction_gate_top.sv
// Path: an accepted slot goes through the queue entry and then the output register.
// Throughput: one slot per cycle while the queue has room; the front part's state
// machine settles each slot combinationally and the two-entry queue absorbs stalls.
// Reset: synchronous, clears the gate state, restores every configuration
// register to its default and empties the queue and the output register.
// ----------------------------------------------------------------------------
// esc_arm_direction_gate_top
// Arm and direction gate for digital ESC frames: front classifier, request
// queue and code-forming back part.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_arm_direction_gate_top #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [eadg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [eadg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             slot_valid,
  output logic                                  slot_ready,
  input  wire eadg_pkg::slot_t                  slot,
  output logic                                  frame_valid,
  input  wire logic                             frame_ready,
  output eadg_pkg::frame_t                      frame
);

  logic           push;
  logic           push_ready;
  eadg_pkg::cmd_t push_data;
  logic           pop;
  logic           pop_valid;
  eadg_pkg::cmd_t pop_data;

  eadg_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .slot_valid (slot_valid),
    .slot_ready (slot_ready),
    .slot       (slot),
    .push       (push),
    .push_ready (push_ready),
    .cmd        (push_data)
  );

  eadg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  eadg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_data    (pop_data),
    .pop         (pop),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

endmodule

`default_nettype wire

>>> hw/rtl/eadg_checker.sv
// ----------------------------------------------------------------------------
// eadg_checker
// Port-level checks of the gate's output frames, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module eadg_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             frame_valid,
  input wire logic             frame_ready,
  input wire eadg_pkg::frame_t frame
);

  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !frame_valid)
  `ASSERT_NEXT(a_stall_hold, clk, rst, frame_valid && !frame_ready, frame_valid && $stable(frame))
  `ASSERT_SAME(a_thr_ready, clk, rst, frame_valid && frame.frame_kind == eadg_pkg::KIND_THR, frame.gate_phase == eadg_pkg::PH_READY)
  `ASSERT_SAME(a_dir_send, clk, rst, frame_valid && frame.frame_kind == eadg_pkg::KIND_DIR, frame.gate_phase == eadg_pkg::PH_SEND)
  `ASSERT_SAME(a_codes_idle, clk, rst, frame_valid && frame.frame_kind != eadg_pkg::KIND_THR, frame.code_a == 11'd0 && frame.code_b == 11'd0 && frame.code_c == 11'd0 && frame.code_d == 11'd0)

endmodule

bind esc_arm_direction_gate_top eadg_checker u_checker (.*);

`default_nettype wire
